>>> src/lsw_pkg.sv
// Package for the small-window LZSS decoder.
// Holds shared constants and the command and status structs between controller
// and datapath. It depends on nothing.
package lsw_pkg;

  localparam int HISTORY_DEPTH_DEF = 32;
  localparam int SIZE_BITS_DEF     = 16;
  localparam int BYTE_BITS         = 8;
  localparam int LEN_BITS          = 3;
  localparam int DIST_BITS         = 5;
  localparam int LEN_BIAS          = 3;
  localparam int RUN_BITS          = 4;
  localparam logic [3:0] FLAG_COUNT = 4'd8;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_DIST = 2'd1;
  localparam logic [1:0] ST_TRUNC    = 2'd2;

  // Source of an emitted result.
  typedef enum logic [2:0] {
    K_LIT,
    K_STORED,
    K_COPY,
    K_ERR_DIST,
    K_ERR_TRUNC
  } kind_t;

  typedef struct packed {
    logic  load_in;
    logic  set_size_hi;
    logic  set_size;
    logic  load_flags;
    logic  start_copy;
    logic  emit;
    kind_t kind;
    logic  run_last;
    logic  trunc;
    logic  token_next;
    logic  clear;
  } lsw_cmd_t;

  typedef struct packed {
    logic in_last;
    logic flag_bit;
    logic hdr_zero;
    logic dist_bad;
    logic flags_last;
    logic copy_last;
    logic end_hit;
    logic o_free;
  } lsw_stat_t;

endpackage

>>> src/lsw_datapath.sv
// Datapath of the small-window LZSS decoder: input latch, counters, history
// memory and output register. Uses lsw_pkg; driven by lsw_ctrl commands.
module lsw_datapath #(
  parameter int HISTORY_DEPTH = lsw_pkg::HISTORY_DEPTH_DEF,
  parameter int SIZE_BITS     = lsw_pkg::SIZE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  lsw_pkg::lsw_cmd_t cmd,
  output lsw_pkg::lsw_stat_t stat,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              run_last,
  output logic              stream_end,
  output logic              stored_mode,
  output logic [1:0]        status
);
  import lsw_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);

  logic [BYTE_BITS-1:0] hist [HISTORY_DEPTH];
  logic [BYTE_BITS-1:0] byte_reg;
  logic                 last_reg;
  logic [BYTE_BITS-1:0] size_high;
  logic [SIZE_BITS-1:0] total_size;
  logic [SIZE_BITS-1:0] out_count;
  logic [BYTE_BITS-1:0] flag_bits;
  logic [3:0]           flags_left;
  logic [AW-1:0]        rp;
  logic [RUN_BITS-1:0]  len_left;
  logic [BYTE_BITS-1:0] rd_data;

  logic [SIZE_BITS-1:0] count_inc;
  logic [DIST_BITS:0]   back_dist;
  logic                 produce;
  logic                 copy_adv;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr;
  logic [BYTE_BITS-1:0] wdata;

  assign count_inc = out_count + SIZE_BITS'(1);
  assign back_dist = {1'b0, byte_reg[DIST_BITS-1:0]} + (DIST_BITS+1)'(1);
  assign produce   = cmd.emit && (cmd.kind == K_LIT || cmd.kind == K_COPY);
  assign copy_adv  = cmd.emit && (cmd.kind == K_COPY);
  assign we        = produce;
  assign waddr     = out_count[AW-1:0];
  assign wdata     = (cmd.kind == K_COPY) ? rd_data : byte_reg;
  // While a copy stalls, the same entry is read again so rd_data holds.
  assign raddr     = copy_adv ? rp + AW'(1) : rp;

  always_comb begin
    stat.in_last    = last_reg;
    stat.flag_bit   = flag_bits[BYTE_BITS-1];
    stat.hdr_zero   = (size_high == '0) && (byte_reg == '0);
    stat.dist_bad   = SIZE_BITS'(back_dist) > out_count;
    stat.flags_last = (flags_left == 4'd1);
    stat.copy_last  = (len_left == RUN_BITS'(1));
    stat.end_hit    = (count_inc == total_size);
    stat.o_free     = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      hist[waddr] <= wdata;
    end
    // A read of the entry written in this cycle sees the new byte.
    if (we && waddr == raddr) begin
      rd_data <= wdata;
    end else begin
      rd_data <= hist[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      byte_reg <= in_byte;
      last_reg <= in_last;
    end
    if (cmd.start_copy) begin
      rp       <= out_count[AW-1:0] - AW'(back_dist);
      len_left <= RUN_BITS'(byte_reg[BYTE_BITS-1 -: LEN_BITS]) + RUN_BITS'(LEN_BIAS);
    end else if (copy_adv) begin
      rp       <= rp + AW'(1);
      len_left <= len_left - RUN_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      size_high  <= '0;
      total_size <= '0;
      out_count  <= '0;
      flag_bits  <= '0;
      flags_left <= '0;
    end else begin
      if (cmd.set_size_hi) begin
        size_high <= byte_reg;
      end
      if (cmd.set_size) begin
        total_size <= SIZE_BITS'({size_high, byte_reg});
        out_count  <= '0;
      end else if (produce) begin
        out_count <= count_inc;
      end
      if (cmd.load_flags) begin
        flag_bits  <= byte_reg;
        flags_left <= FLAG_COUNT;
      end else if (cmd.token_next) begin
        flag_bits  <= {flag_bits[BYTE_BITS-2:0], 1'b0};
        flags_left <= flags_left - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      run_last    <= cmd.run_last;
      stored_mode <= (cmd.kind == K_STORED);
      unique case (cmd.kind)
        K_LIT: begin
          out_byte   <= byte_reg;
          stream_end <= stat.end_hit;
          status     <= cmd.trunc ? ST_TRUNC : ST_OK;
        end
        K_COPY: begin
          out_byte   <= rd_data;
          stream_end <= stat.end_hit;
          status     <= cmd.trunc ? ST_TRUNC : ST_OK;
        end
        K_STORED: begin
          out_byte   <= byte_reg;
          stream_end <= last_reg;
          status     <= ST_OK;
        end
        K_ERR_DIST: begin
          out_byte   <= '0;
          stream_end <= 1'b0;
          status     <= ST_BAD_DIST;
        end
        K_ERR_TRUNC: begin
          out_byte   <= '0;
          stream_end <= 1'b0;
          status     <= ST_TRUNC;
        end
        default: begin
          out_byte   <= '0;
          stream_end <= 1'b0;
          status     <= ST_OK;
        end
      endcase
    end
  end

endmodule

>>> src/lsw_ctrl.sv
// Controller of the small-window LZSS decoder: item sequencing and stream phase.
// Uses lsw_pkg; drives lsw_datapath through the command struct.
module lsw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output lsw_pkg::lsw_cmd_t  cmd,
  input  lsw_pkg::lsw_stat_t stat
);
  import lsw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_EMIT,
    S_COPY_RD,
    S_COPY
  } state_t;

  typedef enum logic [2:0] {
    P_HDR_HI,
    P_HDR_LO,
    P_STORED,
    P_FLAGS,
    P_TOKEN,
    P_DONE
  } phase_t;

  state_t state, state_next;
  phase_t phase, phase_next;
  kind_t  kind_q, kind_q_next;
  logic   tok_done;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    phase_next  = phase;
    kind_q_next = kind_q;
    tok_done    = 1'b0;
    cmd         = '0;
    cmd.kind    = kind_q;
    cmd.load_in = in_valid && in_ready;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        unique case (phase)
          P_HDR_HI: begin
            if (stat.in_last) begin
              kind_q_next = K_ERR_TRUNC;
              state_next  = S_EMIT;
            end else begin
              cmd.set_size_hi = 1'b1;
              phase_next      = P_HDR_LO;
            end
          end
          P_HDR_LO: begin
            cmd.set_size = 1'b1;
            if (stat.in_last) begin
              if (stat.hdr_zero) begin
                cmd.clear  = 1'b1;
                phase_next = P_HDR_HI;
              end else begin
                kind_q_next = K_ERR_TRUNC;
                state_next  = S_EMIT;
              end
            end else begin
              phase_next = stat.hdr_zero ? P_STORED : P_FLAGS;
            end
          end
          P_STORED: begin
            kind_q_next = K_STORED;
            state_next  = S_EMIT;
          end
          P_FLAGS: begin
            cmd.load_flags = 1'b1;
            if (stat.in_last) begin
              kind_q_next = K_ERR_TRUNC;
              state_next  = S_EMIT;
            end else begin
              phase_next = P_TOKEN;
            end
          end
          P_TOKEN: begin
            if (!stat.flag_bit) begin
              kind_q_next = K_LIT;
              state_next  = S_EMIT;
            end else if (stat.dist_bad) begin
              kind_q_next = K_ERR_DIST;
              state_next  = S_EMIT;
            end else begin
              cmd.start_copy = 1'b1;
              state_next     = S_COPY_RD;
            end
          end
          default: begin
            if (stat.in_last) begin
              cmd.clear  = 1'b1;
              phase_next = P_HDR_HI;
            end
          end
        endcase
      end
      S_EMIT: begin
        if (stat.o_free) begin
          cmd.emit     = 1'b1;
          cmd.run_last = 1'b1;
          state_next   = S_IDLE;
          unique case (kind_q)
            K_LIT: begin
              cmd.trunc = stat.in_last && !stat.end_hit;
              tok_done  = 1'b1;
            end
            K_ERR_DIST: begin
              phase_next = P_DONE;
            end
            default: begin
            end
          endcase
          if (stat.in_last) begin
            cmd.clear  = 1'b1;
            phase_next = P_HDR_HI;
          end
        end
      end
      S_COPY_RD: begin
        state_next = S_COPY;
      end
      S_COPY: begin
        cmd.kind = K_COPY;
        if (stat.o_free) begin
          cmd.emit = 1'b1;
          if (stat.copy_last || stat.end_hit) begin
            cmd.run_last = 1'b1;
            cmd.trunc    = stat.in_last && !stat.end_hit;
            tok_done     = 1'b1;
            state_next   = S_IDLE;
            if (stat.in_last) begin
              cmd.clear  = 1'b1;
              phase_next = P_HDR_HI;
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Close a token that produced data and was not the end of the stream.
    if (tok_done && !stat.in_last) begin
      if (stat.end_hit) begin
        phase_next = P_DONE;
      end else begin
        cmd.token_next = 1'b1;
        phase_next     = stat.flags_last ? P_FLAGS : P_TOKEN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      phase  <= P_HDR_HI;
      kind_q <= K_LIT;
    end else begin
      state  <= state_next;
      phase  <= phase_next;
      kind_q <= kind_q_next;
    end
  end

endmodule

>>> src/lzss_small_window_decoder.sv
// LZSS decoder with a 32-byte history window, top level.
// Uses lsw_pkg, lsw_ctrl and lsw_datapath.
//
// Usage: the input channel (in_valid/in_ready) takes one compressed byte per
// item, with in_last on the final byte of a stream. The stream starts with a
// big-endian size; size zero passes bytes through unchanged. The output
// channel (out_valid/out_ready) delivers decoded bytes with run_last on the
// last result caused by an item and status for error reports.
// A literal, stored byte or error result waits while the output register is
// full. A back-reference reads the history memory through its single read
// port, one history read per copied byte.
// One item is in work at a time; in_ready is high only between items.
// A full output register that is not taken stalls the item in work, which
// resumes as soon as out_ready rises; nothing is lost.
// Reset returns the block to header state with no output pending. The history
// memory is not cleared, and no read reaches an entry not yet written.
module lzss_small_window_decoder #(
  parameter int HISTORY_DEPTH = lsw_pkg::HISTORY_DEPTH_DEF,
  parameter int SIZE_BITS     = lsw_pkg::SIZE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       stream_end,
  output logic       stored_mode,
  output logic [1:0] status
);
  import lsw_pkg::*;

  lsw_cmd_t  cmd;
  lsw_stat_t stat;

  lsw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  lsw_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .SIZE_BITS     (SIZE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .stream_end  (stream_end),
    .stored_mode (stored_mode),
    .status      (status)
  );

endmodule

>>> tb/tb_lzss_small_window_decoder.sv
// Testbench for the small-window LZSS decoder: directed streams, then random
// compressed, stored and noise streams under changing idle patterns on both sides.
// Depends on lsw_pkg and lzss_small_window_decoder.

typedef struct packed {
  logic [7:0] data;
  logic       run_last;
  logic       stream_end;
  logic       stored;
  logic [1:0] status;
} dec_result_t;

typedef enum logic [2:0] {
  PH_HDR_HI,
  PH_HDR_LO,
  PH_STORED,
  PH_FLAGS,
  PH_TOKEN,
  PH_DONE
} dec_phase_t;

class lzss_scoreboard;
  logic [7:0]  window [32];
  logic [15:0] produced;
  logic [15:0] size_total;
  logic [7:0]  size_hi;
  logic [7:0]  flags;
  logic [3:0]  flags_left;
  dec_phase_t  phase;
  dec_result_t step_q[$];
  dec_result_t expected_q[$];
  int          errors;

  function new();
    errors = 0;
    restart();
  endfunction

  function void restart();
    produced   = 16'd0;
    size_total = 16'd0;
    size_hi    = 8'd0;
    flags      = 8'd0;
    flags_left = 4'd0;
    phase      = PH_HDR_HI;
  endfunction

  // Appends one decoded byte to the window and to this item's results.
  function void put_byte(input logic [7:0] v);
    produced = produced + 16'd1;
    window[5'(produced - 16'd1)] = v;
    step_q.push_back('{v, 1'b0, produced == size_total, 1'b0, lsw_pkg::ST_OK});
    if (produced == size_total)
      phase = PH_DONE;
  endfunction

  function void push_error(input logic [1:0] code);
    step_q.push_back('{8'd0, 1'b0, 1'b0, 1'b0, code});
  endfunction

  // Predicts the results of one accepted item; returns 1 if the item was ignored.
  function bit note_input(input logic [7:0] b, input logic l);
    logic [3:0]  len;
    logic [15:0] back_dist;
    logic [4:0]  src;
    int          k;
    bit          ignored;
    ignored = 1'b0;
    step_q.delete();
    case (phase)
      PH_HDR_HI: begin
        size_hi = b;
        phase = PH_HDR_LO;
      end
      PH_HDR_LO: begin
        size_total = {size_hi, b};
        produced = 16'd0;
        phase = (size_total == 16'd0) ? PH_STORED : PH_FLAGS;
      end
      PH_STORED: step_q.push_back('{b, 1'b0, l, 1'b1, lsw_pkg::ST_OK});
      PH_FLAGS: begin
        flags = b;
        flags_left = lsw_pkg::FLAG_COUNT;
        phase = PH_TOKEN;
      end
      PH_TOKEN: begin
        if (flags[7]) begin
          len       = 4'(b[7:5]) + 4'(lsw_pkg::LEN_BIAS);
          back_dist = 16'(b[4:0]) + 16'd1;
          if (back_dist > produced) begin
            push_error(lsw_pkg::ST_BAD_DIST);
            phase = PH_DONE;
          end else begin
            for (k = 0; k < int'(len) && phase == PH_TOKEN; k++) begin
              src = produced[4:0] - back_dist[4:0];
              put_byte(window[src]);
            end
          end
        end else begin
          put_byte(b);
        end
        if (phase == PH_TOKEN) begin
          flags = flags << 1;
          flags_left = flags_left - 4'd1;
          if (flags_left == 4'd0)
            phase = PH_FLAGS;
        end
      end
      default: ignored = 1'b1;
    endcase
    if (l) begin
      // The stream ended while a header, flag byte or token was still owed.
      if (phase == PH_HDR_LO || phase == PH_FLAGS || phase == PH_TOKEN) begin
        if (step_q.size() > 0)
          step_q[step_q.size() - 1].status = lsw_pkg::ST_TRUNC;
        else
          push_error(lsw_pkg::ST_TRUNC);
      end
      restart();
    end
    if (step_q.size() > 0)
      step_q[step_q.size() - 1].run_last = 1'b1;
    foreach (step_q[j])
      expected_q.push_back(step_q[j]);
    return ignored;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void compare_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  function void check_result(input dec_result_t got);
    dec_result_t want;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: result with none expected, expected nothing, actual %0h",
               $time, got);
      return;
    end
    want = expected_q.pop_front();
    compare_field("out_byte", want.data, got.data);
    compare_field("run_last", 8'(want.run_last), 8'(got.run_last));
    compare_field("stream_end", 8'(want.stream_end), 8'(got.stream_end));
    compare_field("stored_mode", 8'(want.stored), 8'(got.stored));
    compare_field("status", 8'(want.status), 8'(got.status));
  endfunction
endclass

module tb_lzss_small_window_decoder;
  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'd0;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       run_last;
  logic       stream_end;
  logic       stored_mode;
  logic [1:0] status;

  int             send_idle = 0;
  int             recv_idle = 0;
  int             fed_items = 0;
  logic [7:0]     stream_q[$];
  lzss_scoreboard sb = new();

  lzss_small_window_decoder u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result('{out_byte, run_last, stream_end, stored_mode, status});
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_item(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!sb.note_input(b, l))
      fed_items++;
  endtask

  task automatic send_stream();
    foreach (stream_q[i])
      send_item(stream_q[i], i == stream_q.size() - 1);
  endtask

  task automatic drain(input int tail);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // Builds a well-formed compressed stream; rarely a back-reference reaches
  // past the bytes produced so far, which ends the stream with an error.
  task automatic build_lzss(input int size);
    logic [7:0] group_q[$];
    logic [7:0] flag;
    int         produced;
    int         reach;
    int         len;
    int         k;
    bit         broken;
    stream_q = '{8'(size >> 8), 8'(size)};
    produced = 0;
    broken = 1'b0;
    while (produced < size && !broken) begin
      group_q.delete();
      flag = 8'($urandom);
      for (k = 0; k < 8 && produced < size && !broken; k++) begin
        if (produced > 0 && $urandom_range(99) < 45) begin
          flag[7 - k] = 1'b1;
          len = $urandom_range(3, 10);
          reach = (produced < 32) ? produced : 32;
          if (produced < 32 && $urandom_range(99) == 0) begin
            group_q.push_back({3'(len - 3), 5'($urandom_range(produced, 31))});
            broken = 1'b1;
          end else begin
            group_q.push_back({3'(len - 3), 5'($urandom_range(1, reach) - 1)});
            produced += len;
          end
        end else begin
          flag[7 - k] = 1'b0;
          group_q.push_back(8'($urandom));
          produced++;
        end
      end
      stream_q.push_back(flag);
      foreach (group_q[j])
        stream_q.push_back(group_q[j]);
    end
  endtask

  initial begin
    int sel;
    int cut;
    int ph;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_idle = 37;
    recv_idle = 73;
    // Two literals and a short copy that lands exactly on the size.
    stream_q = '{8'h00, 8'h05, 8'h20, 8'h00, 8'hFF, 8'h01};
    send_stream();
    // Largest size, longest copy, then a distance past the output, then an ignored byte.
    stream_q = '{8'hFF, 8'hFF, 8'h7F, 8'hA5, 8'hE0, 8'h1F, 8'h55};
    send_stream();
    // Stored pass-through, then an empty stored stream.
    stream_q = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'h80};
    send_stream();
    stream_q = '{8'h00, 8'h00};
    send_stream();
    // Streams cut short in the header, before a flag byte and before a token.
    stream_q = '{8'h12};
    send_stream();
    stream_q = '{8'h00, 8'h04};
    send_stream();
    stream_q = '{8'h00, 8'h02, 8'h00};
    send_stream();
    drain(20);

    fed_items = 0;
    for (ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 37 : (ph == 1) ? 73 : 0;
      recv_idle = (ph == 0) ? 73 : (ph == 1) ? 37 : 0;
      while (fed_items < (ph + 1) * 133) begin
        sel = $urandom_range(99);
        if (sel < 75) begin
          build_lzss(($urandom_range(99) < 5) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 48));
          if ($urandom_range(99) < 20)
            repeat ($urandom_range(1, 3)) stream_q.push_back(8'($urandom));
          if ($urandom_range(99) < 12) begin
            cut = $urandom_range(1, stream_q.size() - 1);
            while (stream_q.size() > cut) void'(stream_q.pop_back());
          end
        end else if (sel < 87) begin
          stream_q = '{8'h00, 8'h00};
          repeat ($urandom_range(0, 12)) stream_q.push_back(8'($urandom));
        end else begin
          stream_q.delete();
          repeat ($urandom_range(1, 6)) stream_q.push_back(8'($urandom));
        end
        send_stream();
      end
      drain(20);
    end

    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
    end
    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #12000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
